// ===== design/tcw_pkg.sv =====
package tcw_pkg;

  // Screen geometry.
  localparam int COLS   = 80;
  localparam int ROWS   = 25;
  localparam int CELLS  = COLS * ROWS;
  localparam int ADDR_W = $clog2(CELLS);

  // Field widths of the request and response.
  localparam int MODE_W = 2;
  localparam int CHAR_W = 8;
  localparam int IDX_W  = 11;
  localparam int WORD_W = 16;
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;

  // Operation codes.
  localparam logic [MODE_W-1:0] MODE_PUT   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

  // Character codes and the blank cell.
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;
  localparam logic [WORD_W-1:0] BLANK_CELL   = 16'h0020;

  typedef struct packed {
    logic take;      // latch the accepted request
    logic exec;      // update the cursor, write or read one cell
    logic copy;      // one step of the scroll copy
    logic blank;     // write one blank cell at the sweep counter
    logic load_out;  // load the response register
  } cmd_t;

  typedef struct packed {
    logic is_clear;
    logic is_read;
    logic need_scroll;
    logic copy_last;
    logic blank_last;
    logic out_free;
  } status_t;

endpackage

// ===== design/tcw_req_if.sv =====
interface tcw_req_if;
  logic                        valid;
  logic                        ready;
  logic [tcw_pkg::MODE_W-1:0]  mode;
  logic [tcw_pkg::CHAR_W-1:0]  char_code;
  logic [tcw_pkg::CHAR_W-1:0]  attribute;
  logic [tcw_pkg::IDX_W-1:0]   cell_index;

  modport source (output valid, mode, char_code, attribute, cell_index, input ready);
  modport sink   (input valid, mode, char_code, attribute, cell_index, output ready);
endinterface

// ===== design/tcw_rsp_if.sv =====
interface tcw_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [tcw_pkg::WORD_W-1:0]  cell_word;
  logic [tcw_pkg::COL_W-1:0]   column;
  logic [tcw_pkg::ROW_W-1:0]   row;

  modport source (output valid, cell_word, column, row, input ready);
  modport sink   (input valid, cell_word, column, row, output ready);
endinterface

// ===== design/tcw_ctrl.sv =====
module tcw_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  input  tcw_pkg::status_t status,
  output tcw_pkg::cmd_t    cmd
);

  typedef enum logic [5:0] {
    S_INIT  = 6'b000001,
    S_IDLE  = 6'b000010,
    S_EXEC  = 6'b000100,
    S_COPY  = 6'b001000,
    S_BLANK = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  assign req_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_INIT: begin
        // Clearing pass after reset: every cell gets the blank word.
        cmd.blank = 1'b1;
        if (status.blank_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid) begin
          cmd.take   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        priority if (status.is_clear) begin
          state_next = S_BLANK;
        end else if (status.need_scroll) begin
          state_next = S_COPY;
        end else if (status.is_read) begin
          state_next = S_DONE;
        end else if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end else begin
          state_next = S_DONE;
        end
      end
      S_COPY: begin
        cmd.copy = 1'b1;
        if (status.copy_last) begin
          state_next = S_BLANK;
        end
      end
      S_BLANK: begin
        cmd.blank = 1'b1;
        if (status.blank_last) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_INIT;
      end
    endcase
  end

endmodule

// ===== design/tcw_datapath.sv =====
module tcw_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  tcw_pkg::cmd_t               cmd,
  output tcw_pkg::status_t            status,
  input  logic [tcw_pkg::MODE_W-1:0]  mode,
  input  logic [tcw_pkg::CHAR_W-1:0]  char_code,
  input  logic [tcw_pkg::CHAR_W-1:0]  attribute,
  input  logic [tcw_pkg::IDX_W-1:0]   cell_index,
  input  logic                        rsp_ready,
  output logic                        rsp_valid,
  output logic [tcw_pkg::WORD_W-1:0]  cell_word,
  output logic [tcw_pkg::COL_W-1:0]   column,
  output logic [tcw_pkg::ROW_W-1:0]   row
);

  localparam int AW = tcw_pkg::ADDR_W;

  logic [tcw_pkg::MODE_W-1:0]  mode_q;
  logic [tcw_pkg::CHAR_W-1:0]  char_q;
  logic [tcw_pkg::CHAR_W-1:0]  attr_q;
  logic [tcw_pkg::IDX_W-1:0]   idx_q;

  logic [tcw_pkg::COL_W-1:0]   cur_col, col_calc;
  logic [tcw_pkg::ROW_W-1:0]   cur_row, row_calc;
  logic                        row_adv;
  logic                        need_scroll;
  logic                        put_we;
  logic [AW-1:0]               put_addr;
  logic [tcw_pkg::WORD_W-1:0]  put_data;
  logic                        read_hit;

  logic [AW-1:0]               cnt;
  logic                        copy_last;
  logic                        blank_last;

  logic [tcw_pkg::WORD_W-1:0]  mem [tcw_pkg::CELLS];
  logic                        we, re;
  logic [AW-1:0]               waddr, raddr;
  logic [tcw_pkg::WORD_W-1:0]  wdata, rdata;

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      mode_q <= mode;
      char_q <= char_code;
      attr_q <= attribute;
      idx_q  <= cell_index;
    end
  end

  // Cursor update and the single cell write of a put.
  always_comb begin
    col_calc    = cur_col;
    row_calc    = cur_row;
    row_adv     = 1'b0;
    need_scroll = 1'b0;
    put_we      = 1'b0;
    put_addr    = AW'(cur_row) * AW'(tcw_pkg::COLS) + AW'(cur_col);
    put_data    = {attr_q, char_q};
    if (mode_q == tcw_pkg::MODE_PUT) begin
      unique case (char_q)
        tcw_pkg::CH_NEWLINE: begin
          col_calc = '0;
          row_adv  = 1'b1;
        end
        tcw_pkg::CH_RETURN: begin
          col_calc = '0;
        end
        tcw_pkg::CH_BACKSPACE: begin
          // Backspace at the left edge does nothing.
          if (cur_col != '0) begin
            col_calc = cur_col - tcw_pkg::COL_W'(1);
            put_we   = 1'b1;
            put_addr = put_addr - AW'(1);
            put_data = {attr_q, tcw_pkg::CH_SPACE};
          end
        end
        default: begin
          put_we = 1'b1;
          if (cur_col == tcw_pkg::COL_W'(tcw_pkg::COLS - 1)) begin
            col_calc = '0;
            row_adv  = 1'b1;
          end else begin
            col_calc = cur_col + tcw_pkg::COL_W'(1);
          end
        end
      endcase
      if (row_adv) begin
        // Past the bottom row the row stays put and the screen scrolls.
        if (cur_row == tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1)) begin
          need_scroll = 1'b1;
        end else begin
          row_calc = cur_row + tcw_pkg::ROW_W'(1);
        end
      end
    end else if (mode_q == tcw_pkg::MODE_CLEAR) begin
      col_calc = '0;
      row_calc = '0;
    end
  end

  assign read_hit   = (idx_q < tcw_pkg::IDX_W'(tcw_pkg::CELLS));
  assign copy_last  = (cnt == AW'(tcw_pkg::CELLS - tcw_pkg::COLS));
  assign blank_last = (cnt == AW'(tcw_pkg::CELLS - 1));

  assign status.is_clear    = (mode_q == tcw_pkg::MODE_CLEAR);
  assign status.is_read     = (mode_q == tcw_pkg::MODE_READ);
  assign status.need_scroll = need_scroll;
  assign status.copy_last   = copy_last;
  assign status.blank_last  = blank_last;
  assign status.out_free    = !rsp_valid || rsp_ready;

  // The scroll copy reads cell cnt+COLS and writes the word read in the
  // previous step to cell cnt-1, so one cell moves every cycle.
  always_comb begin
    we    = (cmd.exec && put_we) || (cmd.copy && (cnt != '0)) || cmd.blank;
    re    = (cmd.exec && status.is_read && read_hit) || (cmd.copy && !copy_last);
    raddr = cmd.copy ? cnt + AW'(tcw_pkg::COLS) : AW'(idx_q);
    priority if (cmd.exec) begin
      waddr = put_addr;
      wdata = put_data;
    end else if (cmd.copy) begin
      waddr = cnt - AW'(1);
      wdata = rdata;
    end else begin
      waddr = cnt;
      wdata = tcw_pkg::BLANK_CELL;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.exec) begin
      cnt <= '0;
    end else if ((cmd.copy && !copy_last) || (cmd.blank && !blank_last)) begin
      cnt <= cnt + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_col <= '0;
      cur_row <= '0;
    end else if (cmd.exec) begin
      cur_col <= col_calc;
      cur_row <= row_calc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.load_out) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  // When loaded in the execute cycle the cursor registers still hold the
  // old position, so the freshly computed one is taken.
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      cell_word <= (status.is_read && read_hit) ? rdata : '0;
      column    <= cmd.exec ? col_calc : cur_col;
      row       <= cmd.exec ? row_calc : cur_row;
    end
  end

endmodule

// ===== design/text_console_writer_unit.sv =====
// Text console over an 80 by 25 screen of 16-bit cells (attribute over
// character). Requests arrive on req (mode, char_code, attribute,
// cell_index) and each gives exactly one response on rsp (cell_word,
// column, row), where cell_word is the read cell for a read inside the
// screen, else zero; column and row give the cursor after the request.
// A request is taken only while the engine is idle, one at a time.
// A put that writes one cell, or changes only the cursor, loads its
// response in the execute state when the output register is free and
// then returns to idle, ready for the next request. A read passes
// through the done state before its response is loaded, because the
// cell memory has a registered read port. A put that runs off the bottom
// row copies the screen up one cell per cycle and then blanks the last
// row; a clear blanks all 2000 cells, one per cycle. Both are bounded by
// the single write port of the cell memory. After reset the engine
// writes the blank word to every cell with req.ready low; the cursor
// starts at column 0, row 0. The response sits in an output register;
// while the receiver stalls it holds, and a further request is still
// accepted and processed up to its own response, which waits until the
// register is free.
module text_console_writer_unit (
  input  logic        clk,
  input  logic        rst,
  tcw_req_if.sink     req,
  tcw_rsp_if.source   rsp
);

  tcw_pkg::cmd_t    cmd;
  tcw_pkg::status_t status;

  tcw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .status    (status),
    .cmd       (cmd)
  );

  tcw_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .mode       (req.mode),
    .char_code  (req.char_code),
    .attribute  (req.attribute),
    .cell_index (req.cell_index),
    .rsp_ready  (rsp.ready),
    .rsp_valid  (rsp.valid),
    .cell_word  (rsp.cell_word),
    .column     (rsp.column),
    .row        (rsp.row)
  );

  // A response is never loaded over one the receiver has not taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!rsp.valid || rsp.ready))
    else $error("response register overwritten");

  // An accepted request is executed in the very next cycle.
  a_exec_follows: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> cmd.exec)
    else $error("accepted request not executed");

  // No request is taken while the memory sweep is running.
  a_sweep_blocks: assert property (@(posedge clk) disable iff (rst)
    (cmd.copy || cmd.blank) |-> !req.ready)
    else $error("request accepted during memory sweep");

  // Only one of execute, copy and blank drives the write port at a time.
  a_one_writer: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.exec, cmd.copy, cmd.blank}))
    else $error("conflicting memory commands");

endmodule

// ===== bench/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [tcw_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 1100;
  localparam int CYCLE_LIMIT  = 15_000_000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 50;

  typedef struct packed {
    logic [tcw_pkg::MODE_W-1:0] mode;
    logic [tcw_pkg::CHAR_W-1:0] char_code;
    logic [tcw_pkg::CHAR_W-1:0] attribute;
    logic [tcw_pkg::IDX_W-1:0]  cell_index;
  } console_req_t;

  typedef struct packed {
    logic [tcw_pkg::WORD_W-1:0] cell_word;
    logic [tcw_pkg::COL_W-1:0]  column;
    logic [tcw_pkg::ROW_W-1:0]  row;
  } console_rsp_t;

  typedef struct {
    console_req_t rq;
    int           reps;
    bit           typed;
    console_rsp_t want;
  } plan_step_t;

  logic clk;
  logic rst;

  tcw_req_if req_ch ();
  tcw_rsp_if rsp_ch ();

  text_console_writer_unit u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // Shadow copy of the screen and cursor.
  logic [tcw_pkg::WORD_W-1:0] screen_mem [0:tcw_pkg::CELLS-1];
  int                cur_col;
  int                cur_row;

  console_rsp_t pending_rsp [$];
  plan_step_t   plan [$];

  int  mismatches;
  int  checked;
  int  n_put;
  int  n_read;
  int  n_clear;
  int  n_scroll;
  int  cycle_count;
  bit  hold_rsp;
  bit  no_idle;

  function automatic void blank_screen();
    for (int i = 0; i < tcw_pkg::CELLS; i++) begin
      screen_mem[i] = tcw_pkg::BLANK_CELL;
    end
  endfunction

  function automatic console_rsp_t console_apply(input console_req_t r);
    console_rsp_t o;
    int           col;
    int           rw;
    o   = '0;
    col = cur_col;
    rw  = cur_row;
    case (r.mode)
      tcw_pkg::MODE_PUT: begin
        n_put++;
        if (r.char_code == tcw_pkg::CH_NEWLINE) begin
          col = 0;
          rw++;
        end else if (r.char_code == tcw_pkg::CH_RETURN) begin
          col = 0;
        end else if (r.char_code == tcw_pkg::CH_BACKSPACE) begin
          if (col > 0) begin
            col--;
            screen_mem[rw * tcw_pkg::COLS + col] = {r.attribute, tcw_pkg::CH_SPACE};
          end
        end else begin
          screen_mem[rw * tcw_pkg::COLS + col] = {r.attribute, r.char_code};
          col++;
        end
        if (col >= tcw_pkg::COLS) begin
          col = 0;
          rw++;
        end
        if (rw >= tcw_pkg::ROWS) begin
          n_scroll++;
          for (int i = 0; i < tcw_pkg::CELLS - tcw_pkg::COLS; i++) begin
            screen_mem[i] = screen_mem[i + tcw_pkg::COLS];
          end
          for (int i = tcw_pkg::CELLS - tcw_pkg::COLS; i < tcw_pkg::CELLS; i++) begin
            screen_mem[i] = tcw_pkg::BLANK_CELL;
          end
          rw = tcw_pkg::ROWS - 1;
        end
      end
      tcw_pkg::MODE_CLEAR: begin
        n_clear++;
        blank_screen();
        col = 0;
        rw  = 0;
      end
      tcw_pkg::MODE_READ: begin
        n_read++;
        if (r.cell_index < tcw_pkg::CELLS) begin
          o.cell_word = screen_mem[r.cell_index];
        end
      end
      default: ;
    endcase
    cur_col  = col;
    cur_row  = rw;
    o.column = tcw_pkg::COL_W'(col);
    o.row    = tcw_pkg::ROW_W'(rw);
    return o;
  endfunction

  // Half the time back to back, otherwise mostly a short gap, rarely a long pause.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end else if (r < 98) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  // Text-like traffic: random character puts with edits and line control, plus reads that
  // often look at the cursor row or the row above so that written cells get read back.
  function automatic console_req_t random_request();
    console_req_t r;
    int           pick;
    int           rw;
    r.mode       = tcw_pkg::MODE_PUT;
    r.char_code  = tcw_pkg::CHAR_W'($urandom_range(0, 255));
    r.attribute  = tcw_pkg::CHAR_W'($urandom_range(0, 255));
    r.cell_index = tcw_pkg::IDX_W'($urandom_range(0, 2047));
    pick = $urandom_range(0, 999);
    if (pick < 430) begin
      r.mode = tcw_pkg::MODE_PUT;
    end else if (pick < 510) begin
      r.char_code = tcw_pkg::CH_BACKSPACE;
    end else if (pick < 550) begin
      r.char_code = tcw_pkg::CH_NEWLINE;
    end else if (pick < 580) begin
      r.char_code = tcw_pkg::CH_RETURN;
    end else if (pick < 620) begin
      r.mode = MODE_UNUSED;
    end else if (pick < 635) begin
      r.mode = tcw_pkg::MODE_CLEAR;
    end else begin
      r.mode = tcw_pkg::MODE_READ;
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        rw = cur_row;
        if (rw > 0 && $urandom_range(0, 3) == 0) begin
          rw--;
        end
        r.cell_index = tcw_pkg::IDX_W'(rw * tcw_pkg::COLS
                                       + $urandom_range(0, tcw_pkg::COLS - 1));
      end else if (pick < 85) begin
        r.cell_index = tcw_pkg::IDX_W'($urandom_range(0, tcw_pkg::CELLS - 1));
      end else begin
        r.cell_index = tcw_pkg::IDX_W'($urandom_range(tcw_pkg::CELLS, 2047));
      end
    end
    return r;
  endfunction

  task automatic add_step(input logic [tcw_pkg::MODE_W-1:0] m,
                          input logic [tcw_pkg::CHAR_W-1:0] ch,
                          input logic [tcw_pkg::CHAR_W-1:0] attr,
                          input logic [tcw_pkg::IDX_W-1:0] idx,
                          input int reps, input bit typed,
                          input logic [tcw_pkg::WORD_W-1:0] word,
                          input int col, input int rw);
    plan_step_t s;
    s.rq    = '{mode: m, char_code: ch, attribute: attr, cell_index: idx};
    s.reps  = reps;
    s.typed = typed;
    s.want  = '{cell_word: word, column: tcw_pkg::COL_W'(col), row: tcw_pkg::ROW_W'(rw)};
    plan.push_back(s);
  endtask

  // Offers one request and records its expected response once it is taken.
  task automatic send_request(input console_req_t r, input bit typed,
                              input console_rsp_t want, input int gap);
    console_rsp_t predicted;
    req_ch.valid      <= 1'b1;
    req_ch.mode       <= r.mode;
    req_ch.char_code  <= r.char_code;
    req_ch.attribute  <= r.attribute;
    req_ch.cell_index <= r.cell_index;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    predicted = console_apply(r);
    pending_rsp.push_back(typed ? want : predicted);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk) cycle_count++;
    $display("Timed out after %0d cycles", cycle_count);
    $display("Mismatches found");
    $finish;
  end

  // Response side: random stalls, quiet stretches, and a long hold on request.
  initial begin
    int n;
    rsp_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_rsp) begin
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_rsp = 1'b0;
      end else if (no_idle) begin
        rsp_ch.ready <= 1'b1;
        @(posedge clk);
      end else begin
        rsp_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        n = idle_len();
        if (n > 0) begin
          rsp_ch.ready <= 1'b0;
          repeat (n) @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    console_rsp_t want;
    if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      if (pending_rsp.size() == 0) begin
        $error("Response with no request outstanding: word %h column %0d row %0d",
               rsp_ch.cell_word, rsp_ch.column, rsp_ch.row);
        mismatches++;
      end else begin
        want = pending_rsp.pop_front();
        checked++;
        if (rsp_ch.cell_word !== want.cell_word) begin
          $error("cell_word: expected %h, got %h", want.cell_word, rsp_ch.cell_word);
          mismatches++;
        end
        if (rsp_ch.column !== want.column) begin
          $error("column: expected %0d, got %0d", want.column, rsp_ch.column);
          mismatches++;
        end
        if (rsp_ch.row !== want.row) begin
          $error("row: expected %0d, got %0d", want.row, rsp_ch.row);
          mismatches++;
        end
      end
    end
  end

  initial begin
    console_req_t rq;
    int           random_items;
    int           step;
    int           gap;
    int           burst;
    random_items = 0;
    step         = 0;
    burst        = 0;
    mismatches   = 0;
    checked      = 0;
    hold_rsp     = 1'b0;
    no_idle      = 1'b0;
    blank_screen();
    cur_col = 0;
    cur_row = 0;
    rst               <= 1'b1;
    req_ch.valid      <= 1'b0;
    req_ch.mode       <= tcw_pkg::MODE_PUT;
    req_ch.char_code  <= '0;
    req_ch.attribute  <= '0;
    req_ch.cell_index <= '0;

    // Directed part. After reset, extremes, edits, line end, scroll and clear.
    add_step(tcw_pkg::MODE_READ, 8'h00, 8'h00, 11'd0, 1, 1, tcw_pkg::BLANK_CELL, 0, 0);
    add_step(tcw_pkg::MODE_READ, 8'hFF, 8'hFF, 11'd1999, 1, 1, tcw_pkg::BLANK_CELL, 0, 0);
    add_step(tcw_pkg::MODE_READ, 8'h00, 8'h00, 11'd2000, 1, 1, 16'h0000, 0, 0);
    add_step(tcw_pkg::MODE_READ, 8'h00, 8'h00, 11'h7FF, 1, 1, 16'h0000, 0, 0);
    add_step(MODE_UNUSED, 8'hFF, 8'hFF, 11'h7FF, 1, 1, 16'h0000, 0, 0);
    add_step(tcw_pkg::MODE_PUT, tcw_pkg::CH_BACKSPACE, 8'h5A, 11'd0, 1, 1, 16'h0000, 0, 0);
    add_step(tcw_pkg::MODE_PUT, 8'hFF, 8'hFF, 11'd0, 1, 1, 16'h0000, 1, 0);
    add_step(tcw_pkg::MODE_PUT, 8'h00, 8'h00, 11'd0, 1, 1, 16'h0000, 2, 0);
    add_step(tcw_pkg::MODE_READ, 8'h00, 8'h00, 11'd0, 1, 1, 16'hFFFF, 2, 0);
    add_step(tcw_pkg::MODE_READ, 8'h00, 8'h00, 11'd1, 1, 1, 16'h0000, 2, 0);
    add_step(tcw_pkg::MODE_PUT, tcw_pkg::CH_BACKSPACE, 8'h7E, 11'd0, 1, 1, 16'h0000, 1, 0);
    add_step(tcw_pkg::MODE_READ, 8'h00, 8'h00, 11'd1, 1, 1,
             {8'h7E, tcw_pkg::CH_SPACE}, 1, 0);
    add_step(tcw_pkg::MODE_PUT, tcw_pkg::CH_RETURN, 8'h33, 11'd0, 1, 1, 16'h0000, 0, 0);
    add_step(tcw_pkg::MODE_PUT, tcw_pkg::CH_NEWLINE, 8'h44, 11'd0, 1, 1, 16'h0000, 0, 1);
    add_step(tcw_pkg::MODE_PUT, 8'h5A, 8'h1F, 11'd0, 79, 0, 16'h0000, 0, 0);
    add_step(tcw_pkg::MODE_PUT, 8'h21, 8'h2E, 11'd0, 1, 1, 16'h0000, 0, 2);
    add_step(tcw_pkg::MODE_READ, 8'h00, 8'h00, 11'd159, 1, 1, 16'h2E21, 0, 2);
    add_step(tcw_pkg::MODE_PUT, tcw_pkg::CH_NEWLINE, 8'h00, 11'd0, 22, 0, 16'h0000, 0, 0);
    add_step(tcw_pkg::MODE_PUT, tcw_pkg::CH_NEWLINE, 8'hC3, 11'd0, 1, 1, 16'h0000, 0, 24);
    add_step(tcw_pkg::MODE_READ, 8'h00, 8'h00, 11'd0, 1, 1, 16'h1F5A, 0, 24);
    add_step(tcw_pkg::MODE_READ, 8'h00, 8'h00, 11'd79, 1, 1, 16'h2E21, 0, 24);
    add_step(tcw_pkg::MODE_READ, 8'h00, 8'h00, 11'd1999, 1, 1, tcw_pkg::BLANK_CELL, 0, 24);
    add_step(tcw_pkg::MODE_PUT, 8'h80, 8'h07, 11'd0, 80, 0, 16'h0000, 0, 0);
    add_step(tcw_pkg::MODE_READ, 8'h00, 8'h00, 11'd1840, 1, 0, 16'h0000, 0, 0);
    add_step(tcw_pkg::MODE_CLEAR, 8'h00, 8'hFF, 11'd0, 1, 1, 16'h0000, 0, 0);
    add_step(tcw_pkg::MODE_READ, 8'h00, 8'h00, 11'd1840, 1, 1, tcw_pkg::BLANK_CELL, 0, 0);

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) begin
      for (int k = 0; k < plan[i].reps; k++) begin
        send_request(plan[i].rq, plan[i].typed, plan[i].want, idle_len());
      end
    end

    while (random_items < RANDOM_ITEMS) begin
      // The response side holds off twice while requests keep coming, so the
      // engine fills up and stops taking requests.
      if (step == 250 || step == 900) begin
        hold_rsp = 1'b1;
        burst    = 12;
      end
      if (step == 600) begin
        req_ch.valid <= 1'b0;
        do @(posedge clk); while (pending_rsp.size() != 0);
      end
      no_idle = (step % 250) >= 200;
      rq  = random_request();
      gap = (no_idle || burst > 0) ? 0 : idle_len();
      send_request(rq, 1'b0, '0, gap);
      if (burst > 0) begin
        burst--;
      end
      random_items++;
      step++;
    end

    req_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_rsp.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d puts, %0d reads, %0d clears and %0d scrolls.",
             n_put, n_read, n_clear, n_scroll);
    $display("%0d responses compared in %0d cycles.", checked, cycle_count);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
